// ===== rtl/ukt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ukt_pkg
// Shared widths and codes for the unique-key table with swap-on-delete.
// ----------------------------------------------------------------------------
package ukt_pkg;

	localparam int KEY_W    = 34;
	localparam int CMD_W    = 3;
	localparam int STATUS_W = 3;

	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [KEY_W-1:0]    key_t;

	localparam cmd_t CMD_INSERT = 3'd0;
	localparam cmd_t CMD_DELETE = 3'd1;
	localparam cmd_t CMD_LOOKUP = 3'd2;
	localparam cmd_t CMD_READ   = 3'd3;
	localparam cmd_t CMD_CLEAR  = 3'd4;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_NOT_FOUND = 3'd1;
	localparam status_t ST_DUPLICATE = 3'd2;
	localparam status_t ST_FULL      = 3'd3;
	localparam status_t ST_RANGE     = 3'd4;

endpackage
`default_nettype wire

// ===== rtl/ukt_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ukt_store
// Key and payload memories: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ukt_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int PW    = 32
) (
	input  wire logic               clk,
	input  wire logic               we,
	input  wire logic [AW-1:0]      waddr,
	input  wire ukt_pkg::key_t      wkey,
	input  wire logic [PW-1:0]      wpay,
	input  wire logic [AW-1:0]      raddr,
	output      ukt_pkg::key_t      rkey,
	output      logic [PW-1:0]      rpay
);
	import ukt_pkg::*;

	key_t          key_mem [DEPTH];
	logic [PW-1:0] pay_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr] <= wkey;
			pay_mem[waddr] <= wpay;
		end
		rkey <= key_mem[raddr];
		rpay <= pay_mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/unique_key_table_swap_remove.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// unique_key_table_swap_remove
// Packed key/payload table with linear search and swap-on-delete.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its result appears on
// the result ports for one cycle with done high and cannot be held off. With
// N valid entries, insert, lookup and delete search with one memory read per
// entry, each compared when its registered read returns; a delete hit then
// reads the last entry and writes it into the freed slot, read by index
// waits for its memory read, and clear, an out-of-range read and unused codes
// finish without leaving idle. The single read port of the table memory sets
// this order of steps.
module unique_key_table_swap_remove #(
	parameter int CAPACITY     = 64,
	parameter int PAYLOAD_BITS = 32,
	localparam int IDX_W = $clog2(CAPACITY),
	localparam int CNT_W = $clog2(CAPACITY + 1)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output      logic                    busy,
	input  wire ukt_pkg::cmd_t           command,
	input  wire ukt_pkg::key_t           key,
	input  wire logic [PAYLOAD_BITS-1:0] payload,
	input  wire logic [IDX_W-1:0]        index,
	output      logic                    done,
	output      ukt_pkg::status_t        status,
	output      logic [IDX_W-1:0]        position,
	output      ukt_pkg::key_t           found_key,
	output      logic [PAYLOAD_BITS-1:0] found_payload,
	output      logic [CNT_W-1:0]        entry_count
);
	import ukt_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_LAST   = 3'd2;
	localparam logic [2:0] S_MOVE   = 3'd3;
	localparam logic [2:0] S_RDWAIT = 3'd4;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic [2:0]              state_q;
	cmd_t                    cmd_q;
	key_t                    key_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic [IDX_W-1:0]        idx_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        ptr_q;
	logic                    vld_s1;
	logic [IDX_W-1:0]        addr_s1;
	logic [IDX_W-1:0]        slot_q;
	key_t                    fkey_q;
	logic [PAYLOAD_BITS-1:0] fpay_q;

	logic                    done_q;
	status_t                 status_q;
	logic [IDX_W-1:0]        pos_q;
	key_t                    rkey_q;
	logic [PAYLOAD_BITS-1:0] rpay_q;

	logic                    mem_we;
	logic [IDX_W-1:0]        mem_waddr;
	key_t                    mem_wkey;
	logic [PAYLOAD_BITS-1:0] mem_wpay;
	logic [IDX_W-1:0]        mem_raddr;
	key_t                    mem_rkey;
	logic [PAYLOAD_BITS-1:0] mem_rpay;

	logic issue;
	logic hit;
	logic miss;
	logic [CNT_W-1:0] last_cnt;

	assign issue    = (state_q == S_SEARCH) && (ptr_q < count_q);
	assign hit      = vld_s1 && (mem_rkey == key_q);
	assign miss     = !issue && !vld_s1;
	assign last_cnt = count_q - CNT_W'(1);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[IDX_W-1:0];
		mem_wkey  = key_q;
		mem_wpay  = pay_q;
		mem_raddr = ptr_q[IDX_W-1:0];
		case (state_q)
			S_IDLE: begin
				mem_raddr = index;
			end
			S_SEARCH: begin
				mem_we = !hit && miss && (cmd_q == CMD_INSERT) && (count_q != CAP_CNT);
			end
			S_LAST: begin
				mem_raddr = last_cnt[IDX_W-1:0];
			end
			S_MOVE: begin
				mem_we    = 1'b1;
				mem_waddr = slot_q;
				mem_wkey  = mem_rkey;
				mem_wpay  = mem_rpay;
			end
			default: begin
			end
		endcase
	end

	ukt_store #(
		.DEPTH (CAPACITY),
		.AW    (IDX_W),
		.PW    (PAYLOAD_BITS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wkey  (mem_wkey),
		.wpay  (mem_wpay),
		.raddr (mem_raddr),
		.rkey  (mem_rkey),
		.rpay  (mem_rpay)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			ptr_q    <= '0;
			vld_s1   <= 1'b0;
			done_q   <= 1'b0;
			cmd_q    <= CMD_INSERT;
			key_q    <= '0;
			pay_q    <= '0;
			idx_q    <= '0;
			addr_s1  <= '0;
			slot_q   <= '0;
			fkey_q   <= '0;
			fpay_q   <= '0;
			status_q <= ST_OK;
			pos_q    <= '0;
			rkey_q   <= '0;
			rpay_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q  <= command;
						key_q  <= key;
						pay_q  <= payload;
						idx_q  <= index;
						ptr_q  <= '0;
						vld_s1 <= 1'b0;
						case (command)
							CMD_INSERT, CMD_DELETE, CMD_LOOKUP: begin
								state_q <= S_SEARCH;
							end
							CMD_READ: begin
								if (CNT_W'(index) < count_q) begin
									state_q <= S_RDWAIT;
								end else begin
									done_q   <= 1'b1;
									status_q <= ST_RANGE;
									pos_q    <= '0;
									rkey_q   <= '0;
									rpay_q   <= '0;
								end
							end
							CMD_CLEAR: begin
								count_q  <= '0;
								done_q   <= 1'b1;
								status_q <= ST_OK;
								pos_q    <= '0;
								rkey_q   <= '0;
								rpay_q   <= '0;
							end
							default: begin
								done_q   <= 1'b1;
								status_q <= ST_OK;
								pos_q    <= '0;
								rkey_q   <= '0;
								rpay_q   <= '0;
							end
						endcase
					end
				end
				S_SEARCH: begin
					vld_s1  <= issue;
					addr_s1 <= ptr_q[IDX_W-1:0];
					if (issue) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
					if (hit) begin
						slot_q <= addr_s1;
						fkey_q <= mem_rkey;
						fpay_q <= mem_rpay;
						if (cmd_q == CMD_DELETE) begin
							state_q <= S_LAST;
						end else begin
							state_q  <= S_IDLE;
							done_q   <= 1'b1;
							status_q <= (cmd_q == CMD_INSERT) ? ST_DUPLICATE : ST_OK;
							pos_q    <= addr_s1;
							rkey_q   <= mem_rkey;
							rpay_q   <= mem_rpay;
						end
					end else if (miss) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						if (cmd_q == CMD_INSERT && count_q != CAP_CNT) begin
							count_q  <= count_q + CNT_W'(1);
							status_q <= ST_OK;
							pos_q    <= count_q[IDX_W-1:0];
							rkey_q   <= key_q;
							rpay_q   <= pay_q;
						end else begin
							status_q <= (cmd_q == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
							pos_q    <= '0;
							rkey_q   <= '0;
							rpay_q   <= '0;
						end
					end
				end
				S_LAST: begin
					state_q <= S_MOVE;
				end
				S_MOVE: begin
					state_q  <= S_IDLE;
					count_q  <= last_cnt;
					done_q   <= 1'b1;
					status_q <= ST_OK;
					pos_q    <= slot_q;
					rkey_q   <= fkey_q;
					rpay_q   <= fpay_q;
				end
				S_RDWAIT: begin
					state_q  <= S_IDLE;
					done_q   <= 1'b1;
					status_q <= ST_OK;
					pos_q    <= idx_q;
					rkey_q   <= mem_rkey;
					rpay_q   <= mem_rpay;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign position      = pos_q;
	assign found_key     = rkey_q;
	assign found_payload = rpay_q;
	assign entry_count   = count_q;

endmodule
`default_nettype wire

// ===== rtl/ukt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ukt_checker
// Port-level checks for the unique-key table, bound to the top level.
// ----------------------------------------------------------------------------
module ukt_checker #(
	parameter int CAPACITY = 64,
	parameter int CNT_W    = 7
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                start,
	input wire logic                busy,
	input wire logic                done,
	input wire ukt_pkg::status_t    status,
	input wire logic [CNT_W-1:0]    entry_count
);
	import ukt_pkg::*;

	// a taken word either keeps the block busy or finishes at once
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted word neither busy nor done");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_FULL) |-> entry_count == CNT_W'(CAPACITY))
		else $error("table full reported below capacity");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !start |=> $stable(entry_count))
		else $error("entry count moved while idle");

endmodule

bind unique_key_table_swap_remove ukt_checker #(
	.CAPACITY (CAPACITY),
	.CNT_W    (CNT_W)
) u_ukt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.entry_count (entry_count)
);
`default_nettype wire

// ===== dv/tb_unique_key_table_swap_remove.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_unique_key_table_swap_remove
// Self-checking bench for the unique-key table with swap-on-delete. A shadow
// table predicts status, position, entry and count for every accepted word.
// A directed pass covers empty, duplicate, swap, out-of-range, clear and
// spare-code behavior. Random blocks then fill the table to full, churn it
// and drain it, with random gaps on the command side.
// ----------------------------------------------------------------------------
module tb_unique_key_table_swap_remove;

	import ukt_pkg::*;

	localparam int   TABLE_DEPTH   = 64;
	localparam int   DATA_W        = 32;
	localparam int   RANDOM_WORDS  = 1050;
	localparam int   SETTLE_CYCLES = 100;
	localparam int   KEY_POOL_SIZE = 96;
	localparam cmd_t CMD_SPARE_LO  = 3'd5;
	localparam cmd_t CMD_SPARE_HI  = 3'd7;
	localparam key_t KEY_ALL_ONES  = '1;
	localparam key_t KEY_TOP_DEC   = 34'd9999999999;

	typedef struct {
		cmd_t              cmd;
		key_t              key;
		logic [DATA_W-1:0] data;
		logic [5:0]        idx;
		bit                wait_idle;
	} table_word_t;

	typedef struct {
		status_t           status;
		logic [5:0]        position;
		key_t              found_key;
		logic [DATA_W-1:0] found_payload;
		logic [6:0]        entry_count;
	} table_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	cmd_t              command = CMD_INSERT;
	key_t              key = '0;
	logic [DATA_W-1:0] payload = '0;
	logic [5:0]        index = '0;
	logic              busy;
	logic              done;
	status_t           status;
	logic [5:0]        position;
	key_t              found_key;
	logic [DATA_W-1:0] found_payload;
	logic [6:0]        entry_count;

	table_word_t       pending_words[$];
	table_result_t     predicted_results[$];
	key_t              shadow_keys[TABLE_DEPTH];
	logic [DATA_W-1:0] shadow_payloads[TABLE_DEPTH];
	int                shadow_count = 0;
	key_t              key_pool[KEY_POOL_SIZE];
	int                mismatch_count = 0;
	bit                word_taken = 1'b0;
	int                gap_left = 0;
	int                no_gap_left = 0;

	unique_key_table_swap_remove #(
		.CAPACITY    (TABLE_DEPTH),
		.PAYLOAD_BITS(DATA_W)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.key          (key),
		.payload      (payload),
		.index        (index),
		.done         (done),
		.status       (status),
		.position     (position),
		.found_key    (found_key),
		.found_payload(found_payload),
		.entry_count  (entry_count)
	);

	always #10 clk = ~clk;

	// shadow table: linear search, append on insert, move last into freed slot
	function automatic table_result_t apply_to_table(cmd_t cmd, key_t k,
			logic [DATA_W-1:0] p, logic [5:0] idx);
		table_result_t r;
		int hit;
		int last;
		int i;
		r.status        = ST_OK;
		r.position      = '0;
		r.found_key     = '0;
		r.found_payload = '0;
		hit = -1;
		for (i = 0; i < shadow_count; i++) begin
			if (hit < 0 && shadow_keys[i] == k) begin
				hit = i;
			end
		end
		case (cmd)
			CMD_INSERT: begin
				if (hit >= 0) begin
					r.status        = ST_DUPLICATE;
					r.position      = 6'(hit);
					r.found_key     = shadow_keys[hit];
					r.found_payload = shadow_payloads[hit];
				end else if (shadow_count >= TABLE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_keys[shadow_count]     = k;
					shadow_payloads[shadow_count] = p;
					r.position      = 6'(shadow_count);
					r.found_key     = k;
					r.found_payload = p;
					shadow_count++;
				end
			end
			CMD_DELETE: begin
				if (hit >= 0) begin
					last            = shadow_count - 1;
					r.position      = 6'(hit);
					r.found_key     = shadow_keys[hit];
					r.found_payload = shadow_payloads[hit];
					shadow_keys[hit]     = shadow_keys[last];
					shadow_payloads[hit] = shadow_payloads[last];
					shadow_count         = last;
				end else begin
					r.status = ST_NOT_FOUND;
				end
			end
			CMD_LOOKUP: begin
				if (hit >= 0) begin
					r.position      = 6'(hit);
					r.found_key     = shadow_keys[hit];
					r.found_payload = shadow_payloads[hit];
				end else begin
					r.status = ST_NOT_FOUND;
				end
			end
			CMD_READ: begin
				if (int'(idx) < shadow_count) begin
					r.position      = idx;
					r.found_key     = shadow_keys[idx];
					r.found_payload = shadow_payloads[idx];
				end else begin
					r.status = ST_RANGE;
				end
			end
			CMD_CLEAR: begin
				shadow_count = 0;
			end
			default: begin
			end
		endcase
		r.entry_count = 7'(shadow_count);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	function automatic int pick_gap();
		int r;
		if (no_gap_left > 0) begin
			no_gap_left--;
			return 0;
		end
		r = $urandom_range(99);
		if (r < 3) begin
			no_gap_left = $urandom_range(60, 20);
			return 0;
		end
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(3, 1);
		return $urandom_range(70, 8);
	endfunction

	function automatic key_t random_key();
		return {2'($urandom_range(3)), 32'($urandom)};
	endfunction

	function automatic key_t pick_key();
		if ($urandom_range(99) < 88) return key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
		return random_key();
	endfunction

	function automatic logic [DATA_W-1:0] pick_data();
		int r;
		r = $urandom_range(19);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return $urandom;
	endfunction

	task automatic add_word(input cmd_t cmd, input key_t k, input logic [DATA_W-1:0] p,
			input logic [5:0] idx, input bit wait_idle);
		table_word_t w;
		w.cmd       = cmd;
		w.key       = k;
		w.data      = p;
		w.idx       = idx;
		w.wait_idle = wait_idle;
		pending_words.push_back(w);
	endtask

	// command side
	always @(negedge clk) begin
		logic drive;
		drive = 1'b0;
		if (arst_n) begin
			if (word_taken) begin
				word_taken = 1'b0;
				void'(pending_words.pop_front());
				gap_left = pick_gap();
			end
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_words.size() > 0) begin
				drive = !(pending_words[0].wait_idle && predicted_results.size() > 0);
			end
			if (drive) begin
				command <= pending_words[0].cmd;
				key     <= pending_words[0].key;
				payload <= pending_words[0].data;
				index   <= pending_words[0].idx;
			end
		end
		start <= drive;
	end

	// acceptance, prediction and result check
	always @(posedge clk) begin
		table_result_t want;
		if (arst_n) begin
			if (start && !busy) begin
				want = apply_to_table(command, key, payload, index);
				predicted_results.push_back(want);
				word_taken = 1'b1;
			end
			if (done) begin
				if (predicted_results.size() == 0) begin
					$error("result word with no prediction pending");
					mismatch_count++;
				end else begin
					want = predicted_results.pop_front();
					check_field("status", 64'(want.status), 64'(status));
					check_field("position", 64'(want.position), 64'(position));
					check_field("found_key", 64'(want.found_key), 64'(found_key));
					check_field("found_payload", 64'(want.found_payload),
						64'(found_payload));
					check_field("entry_count", 64'(want.entry_count),
						64'(entry_count));
				end
			end
		end
	end

	initial begin
		int   made;
		int   mode;
		int   len;
		int   r;
		int   i;
		cmd_t c;

		for (i = 0; i < KEY_POOL_SIZE; i++) begin
			key_pool[i] = random_key();
		end
		key_pool[0] = '0;
		key_pool[1] = KEY_TOP_DEC;
		key_pool[2] = KEY_ALL_ONES;
		key_pool[3] = KEY_TOP_DEC + 34'd1;

		// directed
		add_word(CMD_LOOKUP, '0, '0, '0, 1'b0);
		add_word(CMD_DELETE, '0, '1, '0, 1'b0);
		add_word(CMD_READ, '0, '0, '0, 1'b0);
		add_word(CMD_INSERT, '0, '0, '1, 1'b0);
		add_word(CMD_INSERT, KEY_ALL_ONES, '1, '0, 1'b0);
		add_word(CMD_INSERT, KEY_TOP_DEC, 32'ha5a5_5a5a, '0, 1'b0);
		add_word(CMD_INSERT, '0, 32'h1234_5678, '0, 1'b0);
		add_word(CMD_LOOKUP, KEY_ALL_ONES, '0, '0, 1'b0);
		add_word(CMD_READ, '0, '0, 6'd2, 1'b0);
		add_word(CMD_READ, '0, '0, '1, 1'b0);
		add_word(CMD_READ, '0, '0, 6'd3, 1'b0);
		add_word(CMD_DELETE, '0, '0, '0, 1'b1);
		add_word(CMD_READ, '0, '0, '0, 1'b0);
		add_word(CMD_DELETE, KEY_ALL_ONES, '0, '0, 1'b0);
		add_word(CMD_LOOKUP, KEY_ALL_ONES, '0, '0, 1'b0);
		add_word(CMD_SPARE_LO, KEY_TOP_DEC, '1, '1, 1'b0);
		add_word(cmd_t'(CMD_SPARE_LO + 3'd1), '0, '0, '0, 1'b0);
		add_word(CMD_SPARE_HI, KEY_ALL_ONES, '1, '1, 1'b0);
		add_word(CMD_INSERT, KEY_TOP_DEC + 34'd1, '0, '0, 1'b0);
		add_word(CMD_CLEAR, KEY_TOP_DEC, '1, '1, 1'b0);
		add_word(CMD_READ, '0, '0, '0, 1'b0);
		add_word(CMD_LOOKUP, KEY_TOP_DEC, '0, '0, 1'b0);

		// fill to capacity and past it
		made = 0;
		for (i = 0; i < TABLE_DEPTH + 3; i++) begin
			add_word(CMD_INSERT, key_pool[i], pick_data(), '0, 1'b0);
			made++;
		end
		add_word(CMD_READ, '0, '0, '1, 1'b1);
		add_word(CMD_INSERT, key_pool[5], pick_data(), '0, 1'b0);
		made += 2;

		// random blocks: fill, churn, drain
		while (made < RANDOM_WORDS) begin
			mode = $urandom_range(2);
			len  = $urandom_range(80, 20);
			repeat (len) begin
				r = $urandom_range(99);
				case (mode)
					0: c = (r < 80) ? CMD_INSERT : (r < 90) ? CMD_LOOKUP : CMD_READ;
					1: begin
						if (r < 30) c = CMD_INSERT;
						else if (r < 55) c = CMD_DELETE;
						else if (r < 75) c = CMD_LOOKUP;
						else if (r < 94) c = CMD_READ;
						else if (r < 96) c = CMD_CLEAR;
						else c = cmd_t'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
					end
					default: c = (r < 60) ? CMD_DELETE : (r < 75) ? CMD_LOOKUP :
						(r < 90) ? CMD_READ : CMD_INSERT;
				endcase
				add_word(c, pick_key(), pick_data(), 6'($urandom_range(63)),
					$urandom_range(99) < 2);
				made++;
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || predicted_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$error("timeout with %0d words and %0d results outstanding",
			pending_words.size(), predicted_results.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
